// File: hdl/wsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

	localparam int LENGTH_WIDTH = 64;
	localparam logic [63:0] LEN_LIMIT = {64{1'b1}} >> (64 - LENGTH_WIDTH);

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	typedef enum logic [2:0] {
		PH_HDR0 = 3'd0,
		PH_HDR1 = 3'd1,
		PH_EXT  = 3'd2,
		PH_KEY  = 3'd3,
		PH_PAY  = 3'd4,
		PH_DONE = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TRUNC    = 2'd1,
		ST_MISMATCH = 2'd2
	} status_t;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic        final_flag;
		logic [2:0]  reserved_bits;
		logic [3:0]  op_code;
		logic        was_masked;
		logic [63:0] payload_length;
		logic [1:0]  status;
		logic        run_last;
	} result_t;

	typedef struct packed {
		logic    pay_vld;
		logic    sum_vld;
		result_t pay;
		result_t sum;
	} push_t;

endpackage

// File: hdl/websocket_frame_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Receive-side WebSocket frame parser with payload unmasking.
// ----------------------------------------------------------------------------
// Each result enters a four-entry result queue at the byte transfer causing it.
// Throughput: one byte per cycle while the queue has room; the last byte of a
// buffer may queue two results, drained one per cycle while out_ready is high.
// Reset: arst_n clears the parser to await a first header byte and empties the
// queue; the parser also returns to that state after each buffer's final byte.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        buffer_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  payload_byte,
	output logic        final_flag,
	output logic [2:0]  reserved_bits,
	output logic [3:0]  op_code,
	output logic        was_masked,
	output logic [63:0] payload_length,
	output logic [1:0]  status,
	output logic        run_last
);

	wsd_pkg::push_t   push;
	wsd_pkg::result_t head;
	logic             room;
	logic             fire;

	assign in_ready = room;
	assign fire     = in_valid && in_ready;

	wsd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.in_byte    (in_byte),
		.buffer_end (buffer_end),
		.push       (push)
	);

	wsd_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.head      (head),
		.room      (room)
	);

	assign kind           = head.kind;
	assign payload_byte   = head.payload_byte;
	assign final_flag     = head.final_flag;
	assign reserved_bits  = head.reserved_bits;
	assign op_code        = head.op_code;
	assign was_masked     = head.was_masked;
	assign payload_length = head.payload_length;
	assign status         = head.status;
	assign run_last       = head.run_last;

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == wsd_pkg::KIND_SUMMARY |-> run_last)
		else $error("summary result without run_last");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == wsd_pkg::KIND_PAYLOAD |->
		status == wsd_pkg::ST_OK && payload_length == 64'd0 && !was_masked)
		else $error("payload result carries summary fields");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && kind == wsd_pkg::KIND_PAYLOAD && !run_last |=>
		out_valid && kind == wsd_pkg::KIND_SUMMARY)
		else $error("summary does not follow final payload byte");

	a_stall_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty result queue");

endmodule

// File: hdl/wsd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header state machine and payload unmasking, one byte per transfer.
// ----------------------------------------------------------------------------
module wsd_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           in_byte,
	input  logic                 buffer_end,
	output wsd_pkg::push_t       push
);

	wsd_pkg::phase_t  phase_q, phase_n;
	logic [7:0]       hdr_q, hdr_n;
	logic             msk_q, msk_n;
	logic [63:0]      len_q, len_n;
	logic [2:0]       cnt_q, cnt_n;
	logic [31:0]      key_q, key_n;
	logic [63:0]      pc_q, pc_n;
	wsd_pkg::status_t err_q, err_n;

	logic             emit;
	logic [7:0]       key_byte;
	logic             have1;
	wsd_pkg::status_t st;

	always_comb begin
		case (pc_q[1:0])
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// next state
	always_comb begin
		phase_n = phase_q;
		hdr_n   = hdr_q;
		msk_n   = msk_q;
		len_n   = len_q;
		cnt_n   = cnt_q;
		key_n   = key_q;
		pc_n    = pc_q;
		err_n   = err_q;
		emit    = 1'b0;
		unique case (phase_q)
			wsd_pkg::PH_HDR0: begin
				hdr_n   = in_byte;
				phase_n = wsd_pkg::PH_HDR1;
			end
			wsd_pkg::PH_HDR1: begin
				msk_n = in_byte[7];
				if (in_byte[6:0] == 7'd0 && !in_byte[7]) begin
					len_n   = 64'd0;
					phase_n = wsd_pkg::PH_DONE;
				end else if (in_byte[6:0] == wsd_pkg::LEN7_EXT16) begin
					len_n   = 64'd0;
					cnt_n   = 3'd1;
					phase_n = wsd_pkg::PH_EXT;
				end else if (in_byte[6:0] == wsd_pkg::LEN7_EXT64) begin
					len_n   = 64'd0;
					cnt_n   = 3'd7;
					phase_n = wsd_pkg::PH_EXT;
				end else begin
					len_n = {57'd0, in_byte[6:0]};
					if (in_byte[7]) begin
						phase_n = wsd_pkg::PH_KEY;
						cnt_n   = 3'd3;
					end else begin
						phase_n = wsd_pkg::PH_PAY;
					end
				end
			end
			wsd_pkg::PH_EXT: begin
				len_n = {len_q[55:0], in_byte};
				if (cnt_q == 3'd0) begin
					if (len_n > wsd_pkg::LEN_LIMIT)
						err_n = wsd_pkg::ST_MISMATCH;
					if (msk_q) begin
						phase_n = wsd_pkg::PH_KEY;
						cnt_n   = 3'd3;
					end else begin
						phase_n = wsd_pkg::PH_PAY;
					end
				end else begin
					cnt_n = cnt_q - 3'd1;
				end
			end
			wsd_pkg::PH_KEY: begin
				key_n = {key_q[23:0], in_byte};
				if (cnt_q == 3'd0)
					phase_n = wsd_pkg::PH_PAY;
				else
					cnt_n = cnt_q - 3'd1;
			end
			wsd_pkg::PH_PAY: begin
				if (pc_q < len_q) begin
					emit = 1'b1;
					pc_n = pc_q + 64'd1;
				end else begin
					err_n = wsd_pkg::ST_MISMATCH;
				end
			end
			default: ;
		endcase
	end

	// result items
	always_comb begin
		have1 = (phase_n != wsd_pkg::PH_HDR0) && (phase_n != wsd_pkg::PH_HDR1);
		if (phase_n == wsd_pkg::PH_DONE)
			st = wsd_pkg::ST_OK;
		else if (phase_n == wsd_pkg::PH_PAY)
			st = (err_n != wsd_pkg::ST_OK || pc_n != len_n) ?
				wsd_pkg::ST_MISMATCH : wsd_pkg::ST_OK;
		else
			st = wsd_pkg::ST_TRUNC;

		push.pay_vld              = fire && emit;
		push.pay                  = '0;
		push.pay.kind             = wsd_pkg::KIND_PAYLOAD;
		push.pay.payload_byte     = in_byte ^ (msk_q ? key_byte : 8'd0);
		push.pay.run_last         = !buffer_end;

		push.sum_vld              = fire && buffer_end;
		push.sum                  = '0;
		push.sum.kind             = wsd_pkg::KIND_SUMMARY;
		push.sum.final_flag       = hdr_n[7];
		push.sum.reserved_bits    = hdr_n[6:4];
		push.sum.op_code          = hdr_n[3:0];
		push.sum.was_masked       = have1 ? msk_n : 1'b0;
		push.sum.payload_length   = have1 ? len_n : 64'd0;
		push.sum.status           = st;
		push.sum.run_last         = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wsd_pkg::PH_HDR0;
			hdr_q   <= '0;
			msk_q   <= 1'b0;
			len_q   <= '0;
			cnt_q   <= '0;
			key_q   <= '0;
			pc_q    <= '0;
			err_q   <= wsd_pkg::ST_OK;
		end else if (fire) begin
			if (buffer_end) begin
				phase_q <= wsd_pkg::PH_HDR0;
				hdr_q   <= '0;
				msk_q   <= 1'b0;
				len_q   <= '0;
				cnt_q   <= '0;
				key_q   <= '0;
				pc_q    <= '0;
				err_q   <= wsd_pkg::ST_OK;
			end else begin
				phase_q <= phase_n;
				hdr_q   <= hdr_n;
				msk_q   <= msk_n;
				len_q   <= len_n;
				cnt_q   <= cnt_n;
				key_q   <= key_n;
				pc_q    <= pc_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

// File: hdl/wsd_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_out_queue
// Result register queue: up to two pushes per cycle, one pop while out_ready.
// ----------------------------------------------------------------------------
module wsd_out_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  wsd_pkg::push_t   push,
	input  logic             out_ready,
	output logic             out_valid,
	output wsd_pkg::result_t head,
	output logic             room
);

	wsd_pkg::result_t         mem_q [wsd_pkg::QDEPTH];
	logic [wsd_pkg::QAW-1:0]  wr_q, rd_q;
	logic [wsd_pkg::QAW:0]    count_q;
	logic [wsd_pkg::QAW-1:0]  wr1;
	logic                     pop;
	logic [wsd_pkg::QAW:0]    n_push;

	assign out_valid = (count_q != '0);
	assign head      = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign room      = (count_q <= (wsd_pkg::QAW+1)'(wsd_pkg::QDEPTH - 2));
	assign wr1       = wr_q + {{(wsd_pkg::QAW-1){1'b0}}, push.pay_vld};
	assign n_push    = {{wsd_pkg::QAW{1'b0}}, push.pay_vld}
	                 + {{wsd_pkg::QAW{1'b0}}, push.sum_vld};

	always_ff @(posedge clk) begin
		if (push.pay_vld)
			mem_q[wr_q] <= push.pay;
		if (push.sum_vld)
			mem_q[wr1] <= push.sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + n_push[wsd_pkg::QAW-1:0];
			if (pop)
				rd_q <= rd_q + {{(wsd_pkg::QAW-1){1'b0}}, 1'b1};
			count_q <= count_q + n_push - {{wsd_pkg::QAW{1'b0}}, pop};
		end
	end

endmodule
